### design/positional_list_store_macros.svh
// Assertion helpers for the positional list store.
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

`ifndef SYNTHESIS

`define PLS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define PLS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define PLS_ASSERT(lbl, clk, rstn, prop, msg)

`define PLS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### design/pls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

    localparam int POS_W   = 6;
    localparam int VAL_W   = 32;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 32;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_FILL_W = 2;

    typedef enum logic [KIND_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_SHOW   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FAIL  = 2'd1,
        ST_VALUE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_SHOW = 1'b1
    } back_state_t;

    typedef struct packed {
        op_t                    op;
        logic                   pos_zero;
        logic [POS_W-1:0]       position;
        logic [POS_W-1:0]       pos_m1;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

### design/pls_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [pls_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic [pls_pkg::KIND_W-1:0]  s_tuser,
    output logic                             cmd_valid,
    input  wire logic                        cmd_ready,
    output pls_pkg::cmd_t                    cmd
);
    import pls_pkg::*;

    cmd_t                 q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_FILL_W-1:0]  fill_reg, fill_next;
    cmd_t                 in_cmd;
    logic                 push, pop;

    // decode the incoming transaction into a command
    always_comb begin
        in_cmd.op       = op_t'(s_tuser);
        in_cmd.position = s_tdata[POS_W-1:0];
        in_cmd.pos_zero = (s_tdata[POS_W-1:0] == '0);
        in_cmd.pos_m1   = s_tdata[POS_W-1:0] - POS_W'(1);
        in_cmd.value    = s_tdata[POS_W+VAL_W-1:POS_W];
    end

    assign s_tready  = (fill_reg != Q_FILL_W'(Q_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (fill_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        // hold the fill level when both or neither side moves
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

### design/pls_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_back #(
    parameter int CAPACITY = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire pls_pkg::cmd_t               cmd,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [pls_pkg::M_DATA_W-1:0]     m_tdata,
    output logic [pls_pkg::STAT_W-1:0]       m_tuser,
    output logic                             m_tlast
);
    import pls_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    `include "positional_list_store_macros.svh"

    logic signed [VAL_W-1:0] list_reg  [CAPACITY];
    logic signed [VAL_W-1:0] list_next [CAPACITY];
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    back_state_t             state_reg, state_next;

    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic signed [VAL_W-1:0] m_elem_reg, m_elem_next;
    logic                    m_last_reg, m_last_next;

    logic                    out_free, load_out;
    logic                    do_ins, do_del;
    logic [POS_W:0]          pos_x, cnt_x;
    logic                    ins_ok, acc_ok;
    logic [IDX_W-1:0]        rd_idx;
    logic signed [VAL_W-1:0] rd_data;
    logic                    show_end;

    assign out_free = !m_valid_reg || m_tready;
    assign pos_x    = {1'b0, cmd.position};
    assign cnt_x    = (POS_W + 1)'(count_reg);
    assign ins_ok   = !cmd.pos_zero && (pos_x <= cnt_x + 1'b1)
                      && (count_reg < CNT_W'(CAPACITY));
    assign acc_ok   = !cmd.pos_zero && (pos_x <= cnt_x);

    // single read port shared by get and the show walk
    always_comb begin
        priority if (state_reg == BK_SHOW) begin
            rd_idx = idx_reg;
        end else if (cmd.op == OP_GET) begin
            rd_idx = IDX_W'(cmd.pos_m1);
        end else begin
            rd_idx = '0;
        end
    end
    assign rd_data  = list_reg[rd_idx];
    assign show_end = (CNT_W'(rd_idx) + 1'b1 == count_reg);

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        cmd_ready     = 1'b0;
        load_out      = 1'b0;
        do_ins        = 1'b0;
        do_del        = 1'b0;
        m_status_next = m_status_reg;
        m_elem_next   = m_elem_reg;
        m_last_next   = m_last_reg;

        unique case (state_reg)
            BK_IDLE: begin
                if (cmd_valid && out_free) begin
                    load_out      = 1'b1;
                    m_last_next   = 1'b1;
                    m_elem_next   = '0;
                    m_status_next = ST_FAIL;
                    unique case (cmd.op)
                        OP_INSERT: begin
                            cmd_ready = 1'b1;
                            if (ins_ok) begin
                                do_ins        = 1'b1;
                                count_next    = count_reg + 1'b1;
                                m_status_next = ST_OK;
                            end
                        end
                        OP_DELETE: begin
                            cmd_ready = 1'b1;
                            if (acc_ok) begin
                                do_del        = 1'b1;
                                count_next    = count_reg - 1'b1;
                                m_status_next = ST_OK;
                            end
                        end
                        OP_GET: begin
                            cmd_ready = 1'b1;
                            if (acc_ok) begin
                                m_status_next = ST_VALUE;
                                m_elem_next   = rd_data;
                            end
                        end
                        OP_SHOW: begin
                            if (count_reg == '0) begin
                                cmd_ready     = 1'b1;
                                m_status_next = ST_EMPTY;
                            end else begin
                                m_status_next = ST_VALUE;
                                m_elem_next   = rd_data;
                                m_last_next   = show_end;
                                if (show_end) begin
                                    cmd_ready = 1'b1;
                                end else begin
                                    idx_next   = IDX_W'(1);
                                    state_next = BK_SHOW;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_SHOW: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    m_status_next = ST_VALUE;
                    m_elem_next   = rd_data;
                    m_last_next   = show_end;
                    if (show_end) begin
                        cmd_ready  = 1'b1;
                        state_next = BK_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase

        m_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    // each cell keeps, takes its lower or upper neighbor, or takes the new value
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            list_next[i] = list_reg[i];
            if (do_ins) begin
                if ((POS_W + 1)'(i) == pos_x - 1'b1) begin
                    list_next[i] = cmd.value;
                end else if ((POS_W + 1)'(i) >= pos_x) begin
                    list_next[i] = list_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (do_del) begin
                if ((POS_W + 1)'(i) + 1'b1 >= pos_x) begin
                    list_next[i] = list_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            list_reg[i] <= list_next[i];
        end
        m_status_reg <= m_status_next;
        m_elem_reg   <= m_elem_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_elem_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    `PLS_ASSERT(a_count_cap, aclk, aresetn, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `PLS_ASSERT_IMP(a_show_idx, aclk, aresetn, state_reg == BK_SHOW, CNT_W'(idx_reg) < count_reg, "show index past end")
    `PLS_ASSERT_IMP(a_show_cmd, aclk, aresetn, state_reg == BK_SHOW, cmd_valid && cmd.op == OP_SHOW, "show walk without show command")
    `PLS_ASSERT_IMP(a_pop_emits, aclk, aresetn, cmd_ready, load_out, "command retired without a result")

endmodule

`default_nettype wire

### design/positional_list_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  tdata (low bit up)              tuser           tlast
// s_       in   position[5:0], value[37:6], pad  kind[1:0]       -
// m_       out  element[31:0]                   status[1:0]     last of the item's run
//
// A command waits in a two-entry queue, and the back end registers its result for output.
// Insert, delete and get give one result each; show gives one per element, or one empty result.
// Insert and delete shift the register list cells from the position onward in parallel.
// Reset clears the count, state, output valid and queue pointers; list contents are not cleared.
// Either side may stall; the queue keeps taking items while a result waits, until it is full.
module positional_list_store #(
    parameter int CAPACITY = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [pls_pkg::S_DATA_W-1:0] s_tdata,   // position, value
    input  wire logic [pls_pkg::KIND_W-1:0]   s_tuser,   // kind
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [pls_pkg::M_DATA_W-1:0]      m_tdata,   // element
    output logic [pls_pkg::STAT_W-1:0]        m_tuser,   // status
    output logic                              m_tlast
);
    import pls_pkg::*;

    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    pls_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    pls_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
